/* rtl/core/aes_fsb_pkg.sv */
// ----------------------------------------------------------------------------
// aes_fsb_pkg
// shared types, constants and functions for the aes forward s-box
// ----------------------------------------------------------------------------
package aes_fsb_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned TableDepth = 1 << ByteW;

    localparam logic [ByteW-1:0] GF_REDUCE_LOW = 8'h1b;
    localparam logic [ByteW-1:0] GF_TOP_BIT = 8'h80;
    localparam logic [ByteW-1:0] AFFINE_CONST = 8'h63;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [TableDepth-1:0][ByteW-1:0] inv_table_t;

    // gf(2^8) product modulo 0x11b, used only to build the table
    function automatic byte_t gf_mul(byte_t a, byte_t b);
        byte_t acc;
        byte_t aa;
        byte_t bb;
        logic carry;
        acc = '0;
        aa = a;
        bb = b;
        for (int i = 0; i < ByteW; i++)
        begin
            if (bb[0])
            begin
                acc = acc ^ aa;
            end
            carry = |(aa & GF_TOP_BIT);
            aa = {aa[ByteW-2:0], 1'b0};
            if (carry)
            begin
                aa = aa ^ GF_REDUCE_LOW;
            end
            bb = {1'b0, bb[ByteW-1:1]};
        end
        return acc;
    endfunction

    // x^254, the inverse for nonzero x and zero for zero
    function automatic byte_t gf_inv(byte_t x);
        byte_t result;
        byte_t pw;
        result = 8'h01;
        pw = x;
        for (int i = 1; i < ByteW; i++)
        begin
            pw = gf_mul(pw, pw);
            result = gf_mul(result, pw);
        end
        return result;
    endfunction

    function automatic inv_table_t build_inv_table();
        inv_table_t tbl;
        for (int x = 0; x < TableDepth; x++)
        begin
            tbl[x] = gf_inv(byte_t'(x));
        end
        return tbl;
    endfunction

    localparam inv_table_t INV_TABLE = build_inv_table();

    // aes affine transform: x ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63
    function automatic byte_t affine_fwd(byte_t x);
        byte_t r1;
        byte_t r2;
        byte_t r3;
        byte_t r4;
        r1 = {x[6:0], x[7]};
        r2 = {x[5:0], x[7:6]};
        r3 = {x[4:0], x[7:5]};
        r4 = {x[3:0], x[7:4]};
        return x ^ r1 ^ r2 ^ r3 ^ r4 ^ AFFINE_CONST;
    endfunction

endpackage

/* rtl/core/aes_fsb_inv_lookup.sv */
// ----------------------------------------------------------------------------
// aes_fsb_inv_lookup
// gf(2^8) multiplicative inverse by constant table, zero maps to zero
// ----------------------------------------------------------------------------
module aes_fsb_inv_lookup
    import aes_fsb_pkg::*;
(
    input  byte_t data_byte,
    output byte_t field_inverse
);

    assign field_inverse = INV_TABLE[data_byte];

endmodule

/* rtl/core/aes_fsb_affine.sv */
// ----------------------------------------------------------------------------
// aes_fsb_affine
// aes forward affine transform with constant 0x63
// ----------------------------------------------------------------------------
module aes_fsb_affine
    import aes_fsb_pkg::*;
(
    input  byte_t field_inverse,
    output byte_t sbox_byte
);

    assign sbox_byte = affine_fwd(field_inverse);

endmodule

/* rtl/core/aes_forward_sbox.sv */
// ----------------------------------------------------------------------------
// aes_forward_sbox
// byte substitution: gf(2^8) inverse and aes forward s-box value
//
//   channel  handshake              payload
//   req      req_valid/req_ready    data_byte
//   rsp      rsp_valid/rsp_ready    field_inverse, sbox_byte
//
// one byte per cycle sustained while the result side is not stalled; an accepted
// byte is held in the input register, which feeds a table lookup and xor network
// into the result register, one byte in each stage
// reset clears both stage valids, no results pending
// a stalled result holds; the input stage keeps filling until both are full
// ----------------------------------------------------------------------------
module aes_forward_sbox
    import aes_fsb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  byte_t data_byte,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output byte_t field_inverse,
    output byte_t sbox_byte
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    byte_t s1_data_reg;
    logic  rsp_valid_reg;
    logic  rsp_valid_next;
    byte_t inv_reg;
    byte_t sbox_reg;
    byte_t inv_comb;
    byte_t sbox_comb;
    logic  s2_ready;
    logic  s1_load;
    logic  s2_load;

    aes_fsb_inv_lookup u_inv
    (
        .data_byte     (s1_data_reg),
        .field_inverse (inv_comb)
    );

    aes_fsb_affine u_affine
    (
        .field_inverse (inv_comb),
        .sbox_byte     (sbox_comb)
    );

    assign s2_ready  = !rsp_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || s2_ready;
    assign s1_load   = req_valid && req_ready;
    assign s2_load   = s1_valid_reg && s2_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (req_ready)
        begin
            s1_valid_next = req_valid;
        end
        if (s2_ready)
        begin
            rsp_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_data_reg <= data_byte;
        end
        if (s2_load)
        begin
            inv_reg  <= inv_comb;
            sbox_reg <= sbox_comb;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign field_inverse = inv_reg;
    assign sbox_byte     = sbox_reg;

    // result pair is consistent
    a_sbox_matches_inverse : assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> sbox_byte == affine_fwd(field_inverse))
        else $error("sbox byte does not match affine of inverse");

    // an input transfer always lands in the input stage
    a_req_lands : assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> s1_valid_reg)
        else $error("input transfer lost");

    // a moving input stage produces a result
    a_stage_advance : assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> rsp_valid)
        else $error("stage advance lost");

    // input stage cannot be dropped while the output is stalled
    a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input stage dropped under stall");

endmodule

/* tb/sv/aes_forward_sbox_tb.sv */
// ----------------------------------------------------------------------------
// aes_forward_sbox_tb
// Drives bytes into the s-box and checks each result transfer against a
// local predictor. The predictor computes the gf(2^8) inverse as x^254 by
// square and multiply over a carry-less product reduced by 0x11b, then
// applies the aes affine map. Stimulus starts with corner bytes, then
// sweeps all 256 values, then sends random bytes. Both sides idle in
// random bursts, and the receiver holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module aes_forward_sbox_tb;
    import aes_fsb_pkg::*;

    localparam int unsigned RandomCount = 944;
    localparam int unsigned CalmTail = 150;
    localparam int unsigned HoldoffCycles = 60;
    localparam int unsigned DrainCycles = 10;
    localparam int unsigned CycleLimit = 200000;
    localparam logic [14:0] FieldPoly = 15'h11b;
    localparam byte_t CornerBytes [20] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hff,
        8'hfe, 8'h7f, 8'haa, 8'h55, 8'h53, 8'hca, 8'h03, 8'h1b, 8'h63, 8'h8d
    };

    typedef struct packed {
        byte_t inverse;
        byte_t sbox;
    } sbox_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    byte_t data_byte = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    byte_t field_inverse;
    byte_t sbox_byte;

    byte_t pending_bytes [$];
    sbox_pair_t sbox_results_due [$];
    sbox_pair_t due_pair;
    int unsigned total_items = 0;
    int unsigned sent_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned holdoff_left = 0;
    int unsigned holdoffs_done = 0;
    logic calm;

    assign calm = (sent_count + CalmTail >= total_items);

    aes_forward_sbox dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .data_byte(data_byte),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .field_inverse(field_inverse),
        .sbox_byte(sbox_byte)
    );

    always #2 clk = ~clk;

    function automatic byte_t gf_product(byte_t a, byte_t b);
        logic [14:0] wide;
        wide = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                wide = wide ^ (15'(a) << i);
            end
        end
        for (int i = 14; i >= 8; i--)
        begin
            if (wide[i])
            begin
                wide = wide ^ (FieldPoly << (i - 8));
            end
        end
        return wide[7:0];
    endfunction

    // x^254 by square and multiply, zero stays zero
    function automatic byte_t gf_reciprocal(byte_t x);
        byte_t acc;
        byte_t base;
        logic [7:0] power;
        acc = 8'h01;
        base = x;
        power = 8'd254;
        for (int i = 0; i < 8; i++)
        begin
            if (power[i])
            begin
                acc = gf_product(acc, base);
            end
            base = gf_product(base, base);
        end
        return acc;
    endfunction

    function automatic byte_t sbox_affine(byte_t v);
        byte_t s;
        for (int i = 0; i < 8; i++)
        begin
            s[i] = v[i] ^ v[(i + 4) % 8] ^ v[(i + 5) % 8] ^ v[(i + 6) % 8]
                 ^ v[(i + 7) % 8] ^ AFFINE_CONST[i];
        end
        return s;
    endfunction

    function automatic sbox_pair_t substitute(byte_t x);
        sbox_pair_t p;
        p.inverse = gf_reciprocal(x);
        p.sbox = sbox_affine(p.inverse);
        return p;
    endfunction

    task automatic report_mismatch(string what, byte_t got, byte_t want);
        $display("mismatch at cycle %0d: %s got %02h want %02h", cycle_count, what, got, want);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            data_byte <= '0;
            send_gap <= 0;
        end
        else if (!req_valid || req_ready)
        begin
            if (send_gap != 0)
            begin
                req_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                req_valid <= 1'b1;
                data_byte <= pending_bytes.pop_front();
                if (!calm && $urandom_range(0, 7) == 0)
                begin
                    send_gap <= $urandom_range(1, 9);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks results, predicts on each input transfer, paces rsp_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left <= 0;
            sent_count <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (sbox_results_due.size() == 0)
                begin
                    report_mismatch("result with nothing due, inverse", field_inverse, 8'h00);
                end
                else
                begin
                    due_pair = sbox_results_due.pop_front();
                    if (field_inverse !== due_pair.inverse)
                    begin
                        report_mismatch("field_inverse", field_inverse, due_pair.inverse);
                    end
                    if (sbox_byte !== due_pair.sbox)
                    begin
                        report_mismatch("sbox_byte", sbox_byte, due_pair.sbox);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                sbox_results_due.push_back(substitute(data_byte));
                sent_count <= sent_count + 1;
            end
            if (stall_left != 0)
            begin
                rsp_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (holdoff_left != 0)
            begin
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                stall_left <= $urandom_range(0, 8);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_left <= 0;
            holdoffs_done <= 0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
        end
        else if ((holdoffs_done == 0 && sent_count >= 300)
              || (holdoffs_done == 1 && sent_count >= 700))
        begin
            holdoff_left <= HoldoffCycles;
            holdoffs_done <= holdoffs_done + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("aes_forward_sbox_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        foreach (CornerBytes[i])
        begin
            pending_bytes.push_back(CornerBytes[i]);
        end
        for (int v = 0; v < 256; v++)
        begin
            pending_bytes.push_back(byte_t'(v));
        end
        repeat (RandomCount)
        begin
            pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
        end
        total_items = pending_bytes.size();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (sent_count < total_items || sbox_results_due.size() != 0);
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
        begin
            $display("aes_forward_sbox_tb: done, clean");
        end
        else
        begin
            $display("aes_forward_sbox_tb: done, errors");
        end
        $finish;
    end

endmodule
